/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, constants and the sequencer state type for the PWM
// prescaler and period search block.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  // Field widths of the stream payloads.
  localparam int FREQ_W   = 32;
  localparam int DUTY_W   = 16;
  localparam int CLK_W    = 32;
  localparam int PRESC_W  = 16;
  localparam int PERIOD_W = 16;
  localparam int CMP_W    = 16;
  localparam int ACC_W    = 2;

  localparam int S_TDATA_W = 48;  // freq 32 + duty 16
  localparam int M_TDATA_W = 56;  // 51 payload bits padded to 7 bytes

  // Clamped duty fits in ten bits (maximum 1000).
  localparam int DUTY_CL_W = 10;

  // Serial divider: dividend width and divisor width (prescaler times frequency).
  localparam int DIV_N_W   = 32;
  localparam int DIV_D_W   = PRESC_W + FREQ_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // Serial multiplier: multiplicand times a multiplier consumed one bit a cycle.
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam logic [CLK_W-1:0]     CLOCK_RESET = 32'd84000000;
  localparam logic [DUTY_W-1:0]    DUTY_FULL   = 16'd1000;
  localparam logic [PERIOD_W-1:0]  FINE_LOW    = 16'd1000;
  localparam logic [PERIOD_W-1:0]  COARSE_LOW  = 16'd100;
  localparam logic [DIV_D_W-1:0]   FMAX_DIV    = 48'd100;
  localparam logic [DIV_D_W-1:0]   CMP_DIV     = 48'd1000;
  localparam logic [PRESC_W-1:0]   PRESC_LAST  = 16'hffff;

  // Accuracy codes.
  localparam logic [ACC_W-1:0] ACC_NONE   = 2'd0;
  localparam logic [ACC_W-1:0] ACC_FINE   = 2'd1;
  localparam logic [ACC_W-1:0] ACC_COARSE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FMAX_START,
    ST_FMAX_WAIT,
    ST_PRESC_START,
    ST_PRESC_WAIT,
    ST_PF_START,
    ST_PF_WAIT,
    ST_PER_START,
    ST_PER_WAIT,
    ST_DM_START,
    ST_DM_WAIT,
    ST_CMP_START,
    ST_CMP_WAIT,
    ST_FINISH
  } pps_state_t;

endpackage

`default_nettype wire

/* design/pwm_prescaler_period_search.sv */
// ----------------------------------------------------------------------------
// pwm_prescaler_period_search
// Picks a timer prescaler, period and compare value for a requested PWM
// frequency and duty, using a bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
//
//   Channel  | Dir | Signals                      | Payload (lowest bit up)
//   ---------+-----+------------------------------+-----------------------------
//   s_axis   | in  | tvalid, tready, tdata[47:0]  | freq_hz[31:0], duty_permille[15:0]
//   m_axis   | out | tvalid, tready, tdata[55:0]  | prescaler, period_count,
//            |     |                              | compare_value, accuracy_code,
//            |     |                              | freq_clamped, 5 zero bits
//   cfg      | in  | cfg_we, cfg_wdata[31:0]      | timer_clock_hz
//
// An item runs from its input transfer to a loaded result through four
// 32-step divisions (clock/100, prescaler, period, compare) in the shared
// serial divider, two 16-step multiplications and one finishing state. The
// input is ready again in the idle state after that, so a new item is taken
// only once the previous one is through. A zero frequency or a failed search
// ends early.
// The input is ready only while the sequencer is idle. The result register
// lets a new item start while the previous result still waits for its
// transfer. Reset is synchronous and loads the clock register with 84 MHz.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_prescaler_period_search (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration: timer_clock_hz.
  input  wire logic                              cfg_we,
  input  wire logic [pps_pkg::CLK_W-1:0]         cfg_wdata,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: freq_hz[31:0], duty_permille[47:32].
  input  wire logic [pps_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: prescaler[15:0], period_count[31:16], compare_value[47:32],
  // accuracy_code[49:48], freq_clamped[50], zero[55:51].
  output logic [pps_pkg::M_TDATA_W-1:0]          m_axis_tdata
);
  import pps_pkg::*;

  pps_state_t state, state_next;

  logic [CLK_W-1:0]     timer_clock_hz;
  logic [FREQ_W-1:0]    freq;
  logic [DUTY_CL_W-1:0] duty;
  logic [PRESC_W-1:0]   presc;
  logic [PERIOD_W-1:0]  period;
  logic [CMP_W-1:0]     cmp;
  logic [ACC_W-1:0]     acc;
  logic                 clamped;

  logic                 out_valid;
  logic [M_TDATA_W-1:0] out_data;

  // Serial unit handshakes and operands.
  logic                 div_start, div_done;
  logic [DIV_N_W-1:0]   div_n, div_q;
  logic [DIV_D_W-1:0]   div_d;
  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;

  logic                 in_xfer;
  logic                 out_free;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= CLOCK_RESET;
    end else if (cfg_we) begin
      timer_clock_hz <= cfg_wdata;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state. The period equals clock/(prescaler*freq), which only falls as
  // the prescaler grows, so the smallest prescaler that keeps the period within
  // 16 bits is floor((clock>>16)/freq)+1, and both search bounds are checked
  // against that one candidate.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_FMAX_START;
      end
      ST_FMAX_START:  state_next = ST_FMAX_WAIT;
      ST_FMAX_WAIT: begin
        if (div_done) state_next = ST_PRESC_START;
      end
      ST_PRESC_START: begin
        // A zero frequency (also after clamping) skips the search.
        state_next = (freq == '0) ? ST_FINISH : ST_PRESC_WAIT;
      end
      ST_PRESC_WAIT: begin
        if (div_done) begin
          // The candidate prescaler would exceed 65535: no prescaler qualifies.
          state_next = (div_q[PRESC_W-1:0] == PRESC_LAST) ? ST_FINISH : ST_PF_START;
        end
      end
      ST_PF_START:    state_next = ST_PF_WAIT;
      ST_PF_WAIT: begin
        if (mul_done) state_next = ST_PER_START;
      end
      ST_PER_START:   state_next = ST_PER_WAIT;
      ST_PER_WAIT: begin
        if (div_done) begin
          state_next = (div_q[PERIOD_W-1:0] < COARSE_LOW) ? ST_FINISH : ST_DM_START;
        end
      end
      ST_DM_START:    state_next = ST_DM_WAIT;
      ST_DM_WAIT: begin
        if (mul_done) state_next = ST_CMP_START;
      end
      ST_CMP_START:   state_next = ST_CMP_WAIT;
      ST_CMP_WAIT: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:        state_next = ST_IDLE;
    endcase
  end

  // Unit launches and operand selection.
  always_comb begin
    div_start = 1'b0;
    div_n     = timer_clock_hz;
    div_d     = FMAX_DIV;
    mul_start = 1'b0;
    mul_a     = freq;
    mul_b     = presc;
    unique case (state)
      ST_FMAX_START: begin
        div_start = 1'b1;
      end
      ST_PRESC_START: begin
        // floor(floor(clock/65536)/freq)
        div_start = (freq != '0);
        div_n     = DIV_N_W'(timer_clock_hz[CLK_W-1:16]);
        div_d     = DIV_D_W'(freq);
      end
      ST_PF_START: begin
        mul_start = 1'b1;
      end
      ST_PER_START: begin
        div_start = 1'b1;
        div_d     = mul_p;
      end
      ST_DM_START: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(period);
        mul_b     = MUL_B_W'(duty);
      end
      ST_CMP_START: begin
        div_start = 1'b1;
        div_n     = mul_p[DIV_N_W-1:0];
        div_d     = CMP_DIV;
      end
      default: begin
      end
    endcase
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      freq    <= s_axis_tdata[FREQ_W-1:0];
      duty    <= (s_axis_tdata[FREQ_W +: DUTY_W] > DUTY_FULL) ?
                 DUTY_CL_W'(DUTY_FULL) : s_axis_tdata[FREQ_W +: DUTY_CL_W];
      acc     <= ACC_NONE;
      clamped <= 1'b0;
    end
    if (state == ST_FMAX_WAIT && div_done && freq > div_q) begin
      freq    <= div_q;
      clamped <= 1'b1;
    end
    if (state == ST_PRESC_WAIT && div_done) begin
      presc <= div_q[PRESC_W-1:0] + 1'b1;
    end
    if (state == ST_PER_WAIT && div_done) begin
      period <= div_q[PERIOD_W-1:0];
      if (div_q[PERIOD_W-1:0] >= FINE_LOW) begin
        acc <= ACC_FINE;
      end else if (div_q[PERIOD_W-1:0] >= COARSE_LOW) begin
        acc <= ACC_COARSE;
      end
    end
    if (state == ST_CMP_WAIT && div_done) begin
      cmp <= div_q[CMP_W-1:0];
    end
  end

  // Result register; a failed or zero-frequency item reports zero values.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      if (acc == ACC_NONE) begin
        out_data <= {5'b0, clamped, ACC_NONE, {CMP_W{1'b0}}, {PERIOD_W{1'b0}},
                     {PRESC_W{1'b0}}};
      end else begin
        out_data <= {5'b0, clamped, acc, cmp, period, presc};
      end
    end
  end

  pps_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  pps_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

endmodule

`default_nettype wire

/* design/pps_serial_div.sv */
// ----------------------------------------------------------------------------
// pps_serial_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_serial_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [pps_pkg::DIV_N_W-1:0]  dividend,
  input  wire logic [pps_pkg::DIV_D_W-1:0]  divisor,
  output logic                              done,
  output logic [pps_pkg::DIV_N_W-1:0]       quotient
);
  import pps_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_D_W-1:0]   rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W:0]     trial;
  logic                 fits;

  assign trial    = {rem, quo[DIV_N_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= DIV_D_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DIV_D_W-1:0];
      end
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* design/pps_serial_mul.sv */
// ----------------------------------------------------------------------------
// pps_serial_mul
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_serial_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [pps_pkg::MUL_A_W-1:0]  mcand,
  input  wire logic [pps_pkg::MUL_B_W-1:0]  mplier,
  output logic                              done,
  output logic [pps_pkg::MUL_P_W-1:0]       product
);
  import pps_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MUL_A_W-1:0]   a;
  logic [MUL_P_W-1:0]   prod;
  logic [MUL_A_W:0]     sum;

  // The upper 32 bits accumulate; the low 16 bits hold the remaining multiplier bits.
  assign sum     = {1'b0, prod[MUL_P_W-1:MUL_B_W]} + (prod[0] ? {1'b0, a} : '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= mcand;
      prod <= {{MUL_A_W{1'b0}}, mplier};
    end else if (busy) begin
      prod <= {sum, prod[MUL_B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PWM prescaler and period search block. Requests
// (frequency, duty) are streamed in under several timer clock settings, and
// each returned timer setting is compared field by field with a prediction
// worked out from the same request and the current clock register.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  // One returned timer setting, laid out exactly like m_axis_tdata[50:0]:
  // prescaler in the lowest bits, freq_clamped on top.
  typedef struct packed {
    logic             clamp;
    logic [ACC_W-1:0] acc;
    logic [15:0]      cmp;
    logic [15:0]      period;
    logic [15:0]      presc;
  } pwm_setting_t;

  // One row of the directed table. When known is set, the expected setting is
  // the one typed into the row; otherwise it comes from the predictor.
  typedef struct packed {
    logic [31:0]  clock;
    logic [31:0]  freq;
    logic [15:0]  duty;
    logic         known;
    pwm_setting_t want;
  } request_row_t;

  localparam int DIRECTED_ROWS   = 23;
  localparam int RANDOM_CHUNKS   = 9;
  localparam int CHUNK_REQUESTS  = 100;
  localparam int SETTLE_CYCLES   = 200;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [63:0] PERIOD_LIMIT = 64'd65535;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we = 1'b0;
  logic [CLK_W-1:0]      cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;  // freq_hz[31:0], duty_permille[47:32]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // m_axis_tdata: prescaler, period_count, compare_value, accuracy_code,
  // freq_clamped, zero padding (lowest bit up).
  logic [M_TDATA_W-1:0]  m_axis_tdata;

  // Bench copy of the timer clock register; it starts at the reset value.
  logic [31:0] timer_clock_copy = CLOCK_RESET;

  pwm_setting_t pending_settings[$];

  int snd_idle_pct = 0;
  int rx_idle_pct  = 0;
  int requests_sent = 0;
  int settings_seen = 0;
  int clock_writes  = 0;
  int mismatch_count = 0;

  pwm_prescaler_period_search u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted timer setting for one request.
  //
  // The block nominally scans prescalers upward for the first whose period
  // floor(floor(clock / p) / f) lies inside the window. The nested floors
  // equal floor(clock / (p * f)), which never grows with p. So the first
  // prescaler that brings the period down to 65535 or below is
  // floor(clock / (f * 65536)) + 1, and it is the only candidate: if its
  // period is under the lower bound, every larger prescaler is too. That
  // turns the scan into one division, and the fine and coarse searches
  // differ only in which bound that single period clears.
  function automatic pwm_setting_t predict_timer_setting(input logic [31:0] clock_hz,
                                                         input logic [31:0] freq_hz,
                                                         input logic [15:0] duty_pm);
    pwm_setting_t r;
    logic [31:0]  f;
    logic [15:0]  d;
    logic [63:0]  first_presc;
    logic [63:0]  per;
    r = '0;
    f = freq_hz;
    if (f > clock_hz / 100) begin
      f = clock_hz / 100;
      r.clamp = 1'b1;
    end
    d = (duty_pm > DUTY_FULL) ? DUTY_FULL : duty_pm;
    if (f != 0) begin
      first_presc = {32'd0, clock_hz} / ({32'd0, f} << 16) + 64'd1;
      if (first_presc <= {48'd0, PRESC_LAST}) begin
        per = {32'd0, clock_hz} / (first_presc * {32'd0, f});
        if (per >= {48'd0, FINE_LOW}) begin
          r.acc = ACC_FINE;
        end else if (per >= {48'd0, COARSE_LOW}) begin
          r.acc = ACC_COARSE;
        end
        if (r.acc != ACC_NONE && per <= PERIOD_LIMIT) begin
          r.presc  = first_presc[15:0];
          r.period = per[15:0];
          r.cmp    = 16'(({48'd0, d} * per) / {48'd0, DUTY_FULL});
        end else begin
          r.acc = ACC_NONE;
        end
      end
    end
    return r;
  endfunction

  function automatic request_row_t mk_row(input logic [31:0] clock, input logic [31:0] freq,
                                          input logic [15:0] duty, input logic known,
                                          input logic [15:0] presc, input logic [15:0] period,
                                          input logic [15:0] cmp, input logic [ACC_W-1:0] acc,
                                          input logic clamp);
    request_row_t row;
    row.clock = clock;
    row.freq  = freq;
    row.duty  = duty;
    row.known = known;
    row.want  = '{clamp: clamp, acc: acc, cmp: cmp, period: period, presc: presc};
    return row;
  endfunction

  // A request frequency that mostly lands inside the legal range, spread over
  // many decades, with zero, over-range and boundary values mixed in.
  function automatic logic [31:0] pick_freq(input logic [31:0] clock_hz);
    logic [31:0] fmax;
    logic [31:0] v;
    fmax = clock_hz / 100;
    v = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return fmax + $urandom_range(0, 3);
      default: return (fmax != 0) ? (v % fmax) + 32'd1 : v;
    endcase
  endfunction

  // Timer clock for each random chunk; the extremes appear in the directed rows.
  function automatic logic [31:0] pick_clock(input int chunk);
    case (chunk)
      0: return CLOCK_RESET;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(100, 100000);
      4: return 32'd16_000_000;
      5: return $urandom >> $urandom_range(0, 20);
      6: return $urandom_range(100, 5000);
      7: return $urandom;
      default: return 32'd72_000_000;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endtask

  // Writes the clock register once the block has delivered every pending
  // setting, so the change never lands in the middle of a computation.
  // The input is withdrawn first so the last request is not offered again.
  // Entered and left at a falling edge.
  task automatic write_timer_clock(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_settings.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    timer_clock_copy = value;
    clock_writes++;
  endtask

  // Offers one request and holds it until the input transfer completes.
  // Entered and left at a falling edge; tvalid stays high into the next
  // request unless that one starts with an idle cycle.
  task automatic send_request(input logic [31:0] freq, input logic [15:0] duty,
                              input logic known, input pwm_setting_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {duty, freq};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_settings.push_back(known ? want
                                     : predict_timer_setting(timer_clock_copy, freq, duty));
    requests_sent++;
    @(negedge clk);
  endtask

  // The receiver decides its ready at every falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Every output transfer is matched against the oldest pending setting.
  always @(posedge clk) begin : setting_check
    pwm_setting_t got;
    pwm_setting_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = pwm_setting_t'(m_axis_tdata[50:0]);
      settings_seen++;
      if (pending_settings.size() == 0) begin
        note_mismatch("transfer with no request pending", 64'd0, 64'(m_axis_tdata));
      end else begin
        want = pending_settings.pop_front();
        if (got.presc != want.presc) begin
          note_mismatch("prescaler", 64'(want.presc), 64'(got.presc));
        end
        if (got.period != want.period) begin
          note_mismatch("period_count", 64'(want.period), 64'(got.period));
        end
        if (got.cmp != want.cmp) begin
          note_mismatch("compare_value", 64'(want.cmp), 64'(got.cmp));
        end
        if (got.acc != want.acc) begin
          note_mismatch("accuracy_code", 64'(want.acc), 64'(got.acc));
        end
        if (got.clamp != want.clamp) begin
          note_mismatch("freq_clamped", 64'(want.clamp), 64'(got.clamp));
        end
        if (m_axis_tdata[M_TDATA_W-1:51] != '0) begin
          note_mismatch("padding bits", 64'd0, 64'(m_axis_tdata[M_TDATA_W-1:51]));
        end
      end
    end
  end

  initial begin : stimulus
    request_row_t directed_rows[DIRECTED_ROWS];
    logic [31:0]  f;
    logic [15:0]  d;

    // Directed rows. The first group runs on the reset clock without any
    // register write, so it also checks the reset value of the register.
    directed_rows = '{
      // Zero frequency, with the smallest and the largest duty.
      mk_row(CLOCK_RESET, 32'd0, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b0),
      mk_row(CLOCK_RESET, 32'd0, 16'hFFFF, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b0),
      mk_row(CLOCK_RESET, 32'd1000, 16'd500, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      // Largest frequency is clamped to clock/100, which leaves a period of 100.
      mk_row(CLOCK_RESET, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
             16'd1, 16'd100, 16'd100, ACC_COARSE, 1'b1),
      // Exactly at the limit: used as is and not flagged.
      mk_row(CLOCK_RESET, 32'd840000, 16'd1000, 1'b1,
             16'd1, 16'd100, 16'd100, ACC_COARSE, 1'b0),
      // One above the limit, and a duty just above full scale.
      mk_row(CLOCK_RESET, 32'd840001, 16'd1001, 1'b1,
             16'd1, 16'd100, 16'd100, ACC_COARSE, 1'b1),
      mk_row(CLOCK_RESET, 32'd1, 16'd1, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      // Period of exactly 1000 still counts as fine; one hertz more drops to coarse.
      mk_row(CLOCK_RESET, 32'd84000, 16'd999, 1'b1,
             16'd1, 16'd1000, 16'd999, ACC_FINE, 1'b0),
      mk_row(CLOCK_RESET, 32'd84001, 16'd999, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      mk_row(CLOCK_RESET, 32'd50, 16'd333, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      mk_row(CLOCK_RESET, 32'd1281, 16'd700, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      // Largest clock: at 1 Hz no prescaler fits, so the search fails.
      mk_row(32'hFFFF_FFFF, 32'd1, 16'd1000, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b0),
      // Largest period and compare value with prescaler 1.
      mk_row(32'hFFFF_FFFF, 32'd65536, 16'd1000, 1'b1,
             16'd1, 16'd65535, 16'd65535, ACC_FINE, 1'b0),
      mk_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 1'b1,
             16'd1, 16'd100, 16'd0, ACC_COARSE, 1'b1),
      mk_row(32'hFFFF_FFFF, 32'd2, 16'd500, 1'b0, '0, '0, '0, ACC_NONE, 1'b0),
      // Clock under 100 Hz: any nonzero request clamps to zero and fails.
      mk_row(32'd99, 32'd5, 16'd500, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b1),
      mk_row(32'd99, 32'd0, 16'd500, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b0),
      // A zero clock register behaves the same way.
      mk_row(32'd0, 32'd1, 16'd1000, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b1),
      mk_row(32'd0, 32'd0, 16'd0, 1'b1, 16'd0, 16'd0, 16'd0, ACC_NONE, 1'b0),
      mk_row(32'd1, 32'hFFFF_FFFF, 16'd1000, 1'b1,
             16'd0, 16'd0, 16'd0, ACC_NONE, 1'b1),
      // Smallest clock that allows any frequency at all.
      mk_row(32'd100, 32'd1, 16'd0, 1'b1, 16'd1, 16'd100, 16'd0, ACC_COARSE, 1'b0),
      mk_row(32'd100, 32'd2, 16'd1000, 1'b1, 16'd1, 16'd100, 16'd100, ACC_COARSE, 1'b1),
      mk_row(32'd12345678, 32'd1234, 16'd32768, 1'b0, '0, '0, '0, ACC_NONE, 1'b0)
    };

    // Reset is held from time zero and released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 25;
    rx_idle_pct  = 55;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].clock != timer_clock_copy) begin
        write_timer_clock(directed_rows[i].clock);
      end
      send_request(directed_rows[i].freq, directed_rows[i].duty,
                   directed_rows[i].known, directed_rows[i].want);
    end

    // Random requests in chunks, each under its own clock setting. The first
    // third idles mostly on the receive side, the second mostly on the send
    // side, and the last third runs with no idling at all.
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      case (chunk / 3)
        0: begin
          snd_idle_pct = 25;
          rx_idle_pct  = 55;
        end
        1: begin
          snd_idle_pct = 55;
          rx_idle_pct  = 25;
        end
        default: begin
          snd_idle_pct = 0;
          rx_idle_pct  = 0;
        end
      endcase
      write_timer_clock(pick_clock(chunk));
      for (int n = 0; n < CHUNK_REQUESTS; n++) begin
        f = pick_freq(timer_clock_copy);
        d = $urandom_range(0, 1) ? 16'($urandom_range(0, 1000)) : 16'($urandom_range(0, 65535));
        send_request(f, d, 1'b0, '0);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then watch a while longer for any stray output transfer.
    while (pending_settings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed) over %0d clock register writes.",
             requests_sent, DIRECTED_ROWS, clock_writes);
    $display("Checked %0d returned settings; %0d field mismatches.",
             settings_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of about 1000 requests, including stalls.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
